>>> src/gprsp_pkg.sv
package gprsp_pkg;

   // Event codes as they leave on the result channel
   typedef enum logic [1:0] {
      EV_MEMORY = 2'd0,
      EV_ACK    = 2'd1,
      EV_REPORT = 2'd2,
      EV_LOST   = 2'd3
   } event_type;

   // Work codes handed from the classifier to the result stage
   typedef enum logic [2:0] {
      OP_CAPTURE = 3'd0,
      OP_REPORT  = 3'd1,
      OP_MEMORY  = 3'd2,
      OP_ACK     = 3'd3,
      OP_LOST    = 3'd4
   } op_type;

   localparam int POS_WIDTH      = 4;
   localparam int BYTE_WIDTH     = 8;
   localparam int FREQ_WIDTH     = 24;
   localparam int RSP_DATA_WIDTH = 80;

   // Reply byte codes
   localparam logic [7:0] BYTE_MEM_LO = 8'h30;
   localparam logic [7:0] BYTE_MEM_HI = 8'h37;
   localparam logic [7:0] BYTE_ACK    = 8'hd3;
   localparam logic [7:0] BYTE_OPEN   = 8'hd2;

   // Packet byte positions
   localparam logic [3:0] POS_WAVE    = 4'd1;
   localparam logic [3:0] POS_FREQ_HI = 4'd2;
   localparam logic [3:0] POS_FREQ_MD = 4'd3;
   localparam logic [3:0] POS_FREQ_LO = 4'd4;
   localparam logic [3:0] POS_OFFSET  = 4'd5;
   localparam logic [3:0] POS_AMPL    = 4'd6;
   localparam logic [3:0] POS_FILTER  = 4'd7;
   localparam logic [3:0] POS_MEMORY  = 4'd8;

   // One classified byte
   typedef struct packed {
      op_type                 op;
      logic [POS_WIDTH-1:0]   pos;
      logic [BYTE_WIDTH-1:0]  data;
   } cmd_type;

endpackage

>>> src/gprsp_front.sv
module gprsp_front #(
   parameter logic [3:0] LAST_POS = 4'd9
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          rx_byte,
   input  logic                accept,
   output logic                push,
   output gprsp_pkg::cmd_type  cmd
);
   import gprsp_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_PACKET = 2'b10
   } front_state_type;

   front_state_type        state_ff, state_in;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in;

   // Classify the byte and track the packet position
   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      push     = 1'b0;
      cmd.op   = OP_LOST;
      cmd.pos  = '0;
      cmd.data = rx_byte;
      unique case (state_ff)
         ST_IDLE: begin
            if (rx_byte >= BYTE_MEM_LO && rx_byte <= BYTE_MEM_HI) begin
               cmd.op = OP_MEMORY;
               push   = accept;
            end else if (rx_byte == BYTE_ACK) begin
               cmd.op = OP_ACK;
               push   = accept;
            end else if (rx_byte == BYTE_OPEN) begin
               // opening byte only starts the count
               if (accept) begin
                  state_in = ST_PACKET;
                  pos_in   = POS_WAVE;
               end
            end else begin
               cmd.op = OP_LOST;
               push   = accept;
            end
         end
         ST_PACKET: begin
            push    = accept;
            cmd.pos = pos_ff;
            if (pos_ff >= LAST_POS) begin
               cmd.op = OP_REPORT;
               if (accept) begin
                  state_in = ST_IDLE;
                  pos_in   = '0;
               end
            end else begin
               cmd.op = OP_CAPTURE;
               if (accept) begin
                  pos_in = pos_ff + POS_WIDTH'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            pos_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

>>> src/gprsp_queue.sv
module gprsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  gprsp_pkg::cmd_type  push_cmd,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output gprsp_pkg::cmd_type  head_cmd
);
   import gprsp_pkg::*;

   // Two-entry queue between classifier and result stage
   cmd_type     slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> src/gprsp_back.sv
module gprsp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  gprsp_pkg::cmd_type  cmd,
   output logic                cmd_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [79:0]         rsp_tdata,
   output logic [1:0]          rsp_tuser
);
   import gprsp_pkg::*;

   logic [7:0]             wave_ff, wave_in;
   logic [FREQ_WIDTH-1:0]  freq_ff, freq_in;
   logic [7:0]             offset_ff, offset_in;
   logic [7:0]             ampl_ff, ampl_in;
   logic [7:0]             filter_ff, filter_in;
   logic [7:0]             memory_ff, memory_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_WIDTH-1:0]  rsp_data_ff, rsp_data_in;
   event_type                  rsp_kind_ff, rsp_kind_in;

   logic  emits;
   logic  out_free;

   assign emits    = (cmd.op != OP_CAPTURE);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign cmd_pop  = cmd_valid && (!emits || out_free);

   // Capture packet bytes by position
   always_comb begin
      wave_in   = wave_ff;
      freq_in   = freq_ff;
      offset_in = offset_ff;
      ampl_in   = ampl_ff;
      filter_in = filter_ff;
      memory_in = memory_ff;
      if (cmd.op == OP_CAPTURE || cmd.op == OP_REPORT) begin
         unique case (cmd.pos)
            POS_WAVE:    wave_in         = cmd.data;
            POS_FREQ_HI: freq_in[23:16]  = cmd.data;
            POS_FREQ_MD: freq_in[15:8]   = cmd.data;
            POS_FREQ_LO: freq_in[7:0]    = cmd.data;
            POS_OFFSET:  offset_in       = cmd.data;
            POS_AMPL:    ampl_in         = cmd.data;
            POS_FILTER:  filter_in       = cmd.data;
            POS_MEMORY:  memory_in       = cmd.data;
            default: ;
         endcase
      end
   end

   // Build the result; unused fields stay zero
   always_comb begin
      rsp_data_in = '0;
      rsp_kind_in = EV_LOST;
      unique case (cmd.op)
         OP_MEMORY: begin
            rsp_kind_in      = EV_MEMORY;
            rsp_data_in[0]   = 1'b1;
            rsp_data_in[3:1] = cmd.data[2:0];
         end
         OP_ACK: begin
            rsp_kind_in = EV_ACK;
         end
         OP_REPORT: begin
            rsp_kind_in        = EV_REPORT;
            rsp_data_in[11:4]  = wave_in;
            rsp_data_in[35:12] = freq_in;
            rsp_data_in[43:36] = offset_in;
            rsp_data_in[51:44] = ampl_in;
            rsp_data_in[59:52] = filter_in;
            rsp_data_in[67:60] = memory_in;
         end
         OP_LOST: begin
            rsp_kind_in        = EV_LOST;
            rsp_data_in[75:68] = cmd.data;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = cmd_valid && emits;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         wave_ff   <= wave_in;
         freq_ff   <= freq_in;
         offset_ff <= offset_in;
         ampl_ff   <= ampl_in;
         filter_ff <= filter_in;
         memory_ff <= memory_in;
      end
      if (cmd_pop && emits) begin
         rsp_data_ff <= rsp_data_in;
         rsp_kind_ff <= rsp_kind_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

endmodule

>>> src/generator_reply_stream_parser_unit.sv
// Reply stream parser for a serial signal generator.
// req_ channel: one reply byte per transaction in req_tdata[7:0].
// rsp_ channel: one event per transaction. rsp_tuser carries the event kind
//   (memory loaded, acknowledge, state report, lost byte); rsp_tdata carries
//   query flag, memory slot, the captured state packet fields and the lost byte.
// A 0xd2 byte opens a state packet of PACKET_LENGTH bytes, clamped to 9..15;
//   the packet emits a single state report on its last byte and nothing before.
// An event passes from the combinational classifier into the two-entry queue
//   as its byte is accepted; the result stage then loads the output register
//   from the queue head once that register is free to take it.
// Throughput: one byte per cycle while the output is not held, set by the
//   classifier, queue and output register each moving one transaction per cycle.
// When rsp_tready is low the output register holds its event, the queue fills
//   and req_tready drops once both queue entries are taken; bytes that cause
//   no event keep draining while the output waits.
// Reset (synchronous, active high) returns the parser to idle outside a
//   packet and empties the queue and the output register.
module generator_reply_stream_parser_unit #(
   parameter int PACKET_LENGTH = 10
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,    // [7:0] rx_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [79:0]  rsp_tdata,    // [0] query_state, [3:1] memory_slot,
                                      // [11:4] wave_code, [35:12] frequency_word,
                                      // [43:36] offset_code, [51:44] amplitude_code,
                                      // [59:52] filter_code, [67:60] memory_code,
                                      // [75:68] lost_value, [79:76] zero
   output logic [1:0]   rsp_tuser     // [1:0] event_kind
);
   import gprsp_pkg::*;

   // Position of the last packet byte, kept within 8..14
   localparam int LAST_INT = (PACKET_LENGTH < 9) ? 8 :
                             ((PACKET_LENGTH - 1 > 14) ? 14 : PACKET_LENGTH - 1);
   localparam logic [POS_WIDTH-1:0] LAST_POS = POS_WIDTH'(LAST_INT);

   logic     accept;
   logic     push;
   logic     full;
   logic     head_valid;
   logic     pop;
   cmd_type  push_cmd;
   cmd_type  head_cmd;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   gprsp_front #(
      .LAST_POS (LAST_POS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .rx_byte (req_tdata),
      .accept  (accept),
      .push    (push),
      .cmd     (push_cmd)
   );

   gprsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   gprsp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (head_valid),
      .cmd        (head_cmd),
      .cmd_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> src/gprsp_checker.sv
module gprsp_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tready,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [79:0]  rsp_tdata,
   input  logic [1:0]   rsp_tuser
);
   import gprsp_pkg::*;

   // Stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Nothing is offered right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Input is open right after reset
   assert property (@(posedge clock) reset |=> req_tready)
      else $error("input not ready after reset");

   // Memory loaded events always request a state query
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EV_MEMORY |-> rsp_tdata[0])
      else $error("memory loaded without query flag");

   // Events other than lost ones carry neither a lost byte nor padding
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != EV_LOST |-> rsp_tdata[79:68] == 12'd0)
      else $error("lost byte field set on other event");

endmodule

bind generator_reply_stream_parser_unit gprsp_checker u_gprsp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> test/reply_event_checker.sv
module reply_event_checker #(
   parameter int PACKET_LENGTH = 10
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [79:0]  rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   output int           mismatch_count,
   output int           awaited_count,
   output int           memory_events,
   output int           ack_events,
   output int           report_events,
   output int           lost_events
);
   import gprsp_pkg::*;

   // Position of the byte that closes a state packet, clamped to 8..14
   localparam int LAST_POS = (PACKET_LENGTH < 9) ? 8 :
                             (PACKET_LENGTH - 1 > 14) ? 14 : PACKET_LENGTH - 1;

   typedef struct {
      event_type          kind;
      logic               query;
      logic [2:0]         slot;
      logic [7:0]         wave;
      logic signed [23:0] freq;
      logic [7:0]         offset;
      logic [7:0]         ampl;
      logic [7:0]         filter;
      logic [7:0]         memory;
      logic [7:0]         lost;
      logic [3:0]         pad;
   } reply_event;

   // Parser state as seen from outside
   logic               in_packet = 1'b0;
   logic [3:0]         packet_pos = '0;
   logic [7:0]         held_wave = '0;
   logic [23:0]        held_freq = '0;
   logic [7:0]         held_offset = '0;
   logic [7:0]         held_ampl = '0;
   logic [7:0]         held_filter = '0;
   logic [7:0]         held_memory = '0;

   reply_event awaited_events[$];
   int         mismatches = 0;
   int         awaited_level = 0;
   int         kind_tally[4] = '{0, 0, 0, 0};

   assign mismatch_count = mismatches;
   assign awaited_count  = awaited_level;
   assign memory_events  = kind_tally[EV_MEMORY];
   assign ack_events     = kind_tally[EV_ACK];
   assign report_events  = kind_tally[EV_REPORT];
   assign lost_events    = kind_tally[EV_LOST];

   // Advance the parser by one reply byte; returns 1 when the byte yields an event
   function automatic logic decode_reply_byte(input logic [7:0] rx, output reply_event ev);
      ev = '{kind: EV_LOST, default: '0};
      if (in_packet) begin
         case (packet_pos)
            POS_WAVE:    held_wave = rx;
            POS_FREQ_HI: held_freq[23:16] = rx;
            POS_FREQ_MD: held_freq[15:8] = rx;
            POS_FREQ_LO: held_freq[7:0] = rx;
            POS_OFFSET:  held_offset = rx;
            POS_AMPL:    held_ampl = rx;
            POS_FILTER:  held_filter = rx;
            POS_MEMORY:  held_memory = rx;
            default: ;
         endcase
         if (packet_pos >= LAST_POS) begin
            in_packet  = 1'b0;
            packet_pos = '0;
            ev.kind    = EV_REPORT;
            ev.wave    = held_wave;
            ev.freq    = held_freq;
            ev.offset  = held_offset;
            ev.ampl    = held_ampl;
            ev.filter  = held_filter;
            ev.memory  = held_memory;
            return 1'b1;
         end
         packet_pos = packet_pos + 4'd1;
         return 1'b0;
      end
      // Outside a packet every byte is classified
      if (rx >= BYTE_MEM_LO && rx <= BYTE_MEM_HI) begin
         ev.kind  = EV_MEMORY;
         ev.query = 1'b1;
         ev.slot  = rx[2:0];
         return 1'b1;
      end
      if (rx == BYTE_ACK) begin
         ev.kind = EV_ACK;
         return 1'b1;
      end
      if (rx == BYTE_OPEN) begin
         in_packet  = 1'b1;
         packet_pos = POS_WAVE;
         return 1'b0;
      end
      ev.kind = EV_LOST;
      ev.lost = rx;
      return 1'b1;
   endfunction

   task automatic check_field(input string what, input logic [23:0] want,
                              input logic [23:0] got);
      if (want !== got) begin
         $display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
         mismatches++;
      end
   endtask

   task automatic compare_event(input reply_event want, input reply_event got);
      check_field("event_kind", 24'(want.kind), 24'(got.kind));
      check_field("query_state", 24'(want.query), 24'(got.query));
      check_field("memory_slot", 24'(want.slot), 24'(got.slot));
      check_field("wave_code", 24'(want.wave), 24'(got.wave));
      check_field("frequency_word", want.freq, got.freq);
      check_field("offset_code", 24'(want.offset), 24'(got.offset));
      check_field("amplitude_code", 24'(want.ampl), 24'(got.ampl));
      check_field("filter_code", 24'(want.filter), 24'(got.filter));
      check_field("memory_code", 24'(want.memory), 24'(got.memory));
      check_field("lost_value", 24'(want.lost), 24'(got.lost));
      check_field("tdata padding", 24'(want.pad), 24'(got.pad));
   endtask

   // Predict on accepted bytes, compare on accepted events
   always @(posedge clock) begin
      reply_event want;
      reply_event got;
      if (reset) begin
         in_packet   = 1'b0;
         packet_pos  = '0;
         held_wave   = '0;
         held_freq   = '0;
         held_offset = '0;
         held_ampl   = '0;
         held_filter = '0;
         held_memory = '0;
         awaited_events.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            if (decode_reply_byte(req_tdata, want))
               awaited_events.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.kind   = event_type'(rsp_tuser);
            got.query  = rsp_tdata[0];
            got.slot   = rsp_tdata[3:1];
            got.wave   = rsp_tdata[11:4];
            got.freq   = rsp_tdata[35:12];
            got.offset = rsp_tdata[43:36];
            got.ampl   = rsp_tdata[51:44];
            got.filter = rsp_tdata[59:52];
            got.memory = rsp_tdata[67:60];
            got.lost   = rsp_tdata[75:68];
            got.pad    = rsp_tdata[79:76];
            kind_tally[rsp_tuser]++;
            if (awaited_events.size() == 0) begin
               $display("%0t unexpected event: expected none, got kind %0d data %h",
                        $time, rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want = awaited_events.pop_front();
               compare_event(want, got);
            end
         end
      end
      awaited_level <= awaited_events.size();
   end

endmodule

>>> test/tb_generator_reply_stream_parser_unit.sv
module tb_generator_reply_stream_parser_unit;
   import gprsp_pkg::*;

   localparam int PACKET_BYTES = 10;
   localparam int RANDOM_BYTES = 1350;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 80;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   int mismatch_count;
   int awaited_count;
   int memory_events;
   int ack_events;
   int report_events;
   int lost_events;

   int bytes_sent = 0;
   int burst_left = 0;

   generator_reply_stream_parser_unit #(
      .PACKET_LENGTH(PACKET_BYTES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   reply_event_checker #(
      .PACKET_LENGTH(PACKET_BYTES)
   ) event_watch (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .mismatch_count(mismatch_count),
      .awaited_count(awaited_count),
      .memory_events(memory_events),
      .ack_events(ack_events),
      .report_events(report_events),
      .lost_events(lost_events)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   // Receiver: stall pattern follows bits [7:6] of the receiver cycle count, plus long hold-offs
   initial begin
      int unsigned rcv_cycle;
      int          hold_left;
      int          next_hold_at;
      logic        ready_next;
      rcv_cycle    = 0;
      hold_left    = 0;
      next_hold_at = 500;
      forever begin
         @(posedge clock);
         rcv_cycle++;
         if (hold_left == 0 && next_hold_at <= 1100 && bytes_sent >= next_hold_at) begin
            hold_left    = HOLD_CYCLES;
            next_hold_at = next_hold_at + 600;
         end
         if (hold_left != 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            case (rcv_cycle[7:6])
               2'd0: ready_next = 1'b1;
               2'd1: ready_next = 1'($urandom_range(0, 1));
               2'd2: ready_next = ($urandom_range(0, 9) != 0);
               default: ready_next = (rcv_cycle[1:0] == 2'd0);
            endcase
         end
         rsp_tready <= ready_next;
      end
   end

   // Offer one byte and wait for its transaction; bursts mostly end in random gaps
   task automatic drive_byte(input logic [7:0] rx);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stop sending until every awaited event has come out
   task automatic drain_events();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
   endtask

   // Packet payload: mostly random, sometimes a code that is special outside a packet
   function automatic logic [7:0] payload_byte();
      case ($urandom_range(0, 9))
         0: return BYTE_MEM_LO + 8'($urandom_range(0, 7));
         1: return ($urandom_range(0, 1) != 0) ? BYTE_ACK : BYTE_OPEN;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_packet(input logic [7:0] wave, input logic [23:0] freq,
                              input logic [7:0] offset, input logic [7:0] ampl,
                              input logic [7:0] filter, input logic [7:0] memory);
      drive_byte(BYTE_OPEN);
      drive_byte(wave);
      drive_byte(freq[23:16]);
      drive_byte(freq[15:8]);
      drive_byte(freq[7:0]);
      drive_byte(offset);
      drive_byte(ampl);
      drive_byte(filter);
      drive_byte(memory);
      for (int k = 9; k < PACKET_BYTES; k++) drive_byte(payload_byte());
   endtask

   initial begin
      int pick;
      logic mid_drain_done;
      mid_drain_done = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: range edges of the classifier, then packets with extreme fields
      drive_byte(BYTE_MEM_LO);
      drive_byte(BYTE_MEM_HI);
      drive_byte(BYTE_MEM_LO - 8'd1);
      drive_byte(BYTE_MEM_HI + 8'd1);
      drive_byte(BYTE_ACK);
      drive_byte(8'h00);
      drive_byte(8'hff);
      // recognized codes inside a packet are plain data
      send_packet(8'hff, 24'h800000, BYTE_MEM_HI, BYTE_ACK, BYTE_OPEN, 8'hff);
      send_packet(8'h00, 24'h7fffff, 8'hff, 8'h00, 8'hff, 8'h00);
      drain_events();

      // Random: mostly well-formed replies, some noise and cut-short packets
      while (bytes_sent < RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            drive_byte(BYTE_OPEN);
            for (int k = 1; k < PACKET_BYTES; k++) drive_byte(payload_byte());
         end else if (pick < 70) begin
            drive_byte(BYTE_MEM_LO + 8'($urandom_range(0, 7)));
         end else if (pick < 80) begin
            drive_byte(BYTE_ACK);
         end else if (pick < 93) begin
            drive_byte(8'($urandom_range(0, 255)));
         end else begin
            // packet cut short; following bytes get swallowed as payload
            drive_byte(BYTE_OPEN);
            repeat ($urandom_range(1, 8)) drive_byte(payload_byte());
         end
         if (!mid_drain_done && bytes_sent >= 800) begin
            drain_events();
            mid_drain_done = 1'b1;
         end
      end

      // Wind down
      drain_events();
      repeat (8) @(posedge clock);
      $display("covered %0d reply bytes with stalls on both sides; events seen: %0d memory,",
               bytes_sent, memory_events);
      $display("  %0d acknowledge, %0d state report, %0d lost", ack_events, report_events,
               lost_events);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
